// ----- rtl/core/bounded_deque_with_sort_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the bounded deque.
// Each macro samples on clk and is disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_SORT_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SORT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define BDQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque check failed: next-cycle implication");

`endif

// ----- rtl/core/bdq_pkg.sv -----
// ---------------------------------------------------------------------------
// bdq_pkg
// Types and codes shared by the deque cells and the deque controller.
// ---------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] value_in;
    logic [4:0]         position;
  } bdq_req_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [1:0]         status;
    logic [4:0]         occupancy;
  } bdq_rsp_t;

  localparam logic [3:0] ACT_PUSH_FRONT = 4'd0;
  localparam logic [3:0] ACT_PUSH_BACK  = 4'd1;
  localparam logic [3:0] ACT_POP_FRONT  = 4'd2;
  localparam logic [3:0] ACT_POP_BACK   = 4'd3;
  localparam logic [3:0] ACT_PEEK_FRONT = 4'd4;
  localparam logic [3:0] ACT_PEEK_BACK  = 4'd5;
  localparam logic [3:0] ACT_INSERT     = 4'd6;
  localparam logic [3:0] ACT_READ_AT    = 4'd7;
  localparam logic [3:0] ACT_REVERSE    = 4'd8;
  localparam logic [3:0] ACT_SORT       = 4'd9;
  localparam logic [3:0] ACT_CLEAR      = 4'd10;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Width of the position and count carried to the cells; covers a depth of 1024.
  localparam int PTR_W = 11;

  typedef enum logic [2:0] {
    MODE_HOLD,
    MODE_PUSHF,
    MODE_LOAD,
    MODE_POPF,
    MODE_INSERT,
    MODE_ROT,
    MODE_SORT_EVEN,
    MODE_SORT_ODD
  } bdq_mode_t;

  typedef struct packed {
    bdq_mode_t        mode;
    logic [PTR_W-1:0] pos;
    logic [PTR_W-1:0] cnt;
  } bdq_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/bounded_deque_with_sort.sv -----
// ---------------------------------------------------------------------------
// bounded_deque_with_sort
// Fixed-depth double-ended queue of signed words held in a row of cells.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on req/req_valid/req_stall, one action per item; every
//   item yields one response on rsp/rsp_valid/rsp_stall with the word read
//   (zero if none), a status and the occupancy after the action.
//   Words are kept in logical order, cell i holding position i from the front.
//   For push, pop, peek, insert, read_at and clear the response is registered
//   at the accepting edge and shows on the next cycle, and a new item can be
//   taken in that cycle while the response drains, unless rsp_stall is high.
//   Reverse runs one cell rotation per step, targeting occupancy-1 down to 1.
//   Sort runs DEPTH rounds of odd-even transposition through the row.
//   Reverse and sort on fewer than two words finish at once.
//   req_stall is high while a reverse or sort runs, and while a response is
//   held because rsp_stall is high; a held response does not change.
//   Reset empties the deque; stored words keep stale values that are never read.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bounded_deque_with_sort_macros.svh"

module bounded_deque_with_sort #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  bdq_pkg::bdq_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output bdq_pkg::bdq_rsp_t rsp
);
  import bdq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] RND_LAST = CNT_W'(DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_REV  = 2'd1;
  localparam logic [1:0] S_SORT = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [CNT_W-1:0] rev_t;
  logic [CNT_W-1:0] rev_t_next;
  logic [CNT_W-1:0] rnd;
  logic [CNT_W-1:0] rnd_next;
  bdq_rsp_t         rsp_next;
  logic             rsp_load;
  logic             acc;

  bdq_ctrl_t                    ctrl;
  logic signed [WORD_WIDTH-1:0] word_in;
  logic signed [WORD_WIDTH-1:0] cells_q [DEPTH];
  logic [IDX_W-1:0]             rd_idx;
  logic                         rd_en;
  logic signed [WORD_WIDTH-1:0] rd_word;
  logic [CMP_W-1:0]             pos_ext;
  logic [CMP_W-1:0]             cnt_ext;
  logic                         is_front;

  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign acc       = req_valid && !req_stall;
  assign word_in   = WORD_WIDTH'($signed(req.value_in));
  assign pos_ext   = CMP_W'(req.position);
  assign cnt_ext   = CMP_W'(cnt);
  assign is_front  = req.action inside {ACT_POP_FRONT, ACT_PEEK_FRONT};
  assign rd_word   = cells_q[rd_idx];

  // Row of cells.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [WORD_WIDTH-1:0] left_w;
    logic signed [WORD_WIDTH-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = word_in;
    end else begin : g_mid
      assign left_w = cells_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_w = cells_q[g];
    end else begin : g_inner
      assign right_w = cells_q[g+1];
    end

    bdq_cell #(
      .WORD_WIDTH(WORD_WIDTH),
      .INDEX     (g)
    ) u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .word (word_in),
      .left (left_w),
      .right(right_w),
      .first(cells_q[0]),
      .value(cells_q[g])
    );
  end

  always_comb begin
    state_next         = state;
    cnt_next           = cnt;
    rev_t_next         = rev_t;
    rnd_next           = rnd;
    rsp_load           = 1'b0;
    rsp_next.status    = ST_OK;
    rsp_next.value_out = '0;
    rsp_next.occupancy = '0;
    rd_idx             = '0;
    rd_en              = 1'b0;
    ctrl.mode          = MODE_HOLD;
    ctrl.pos           = '0;
    ctrl.cnt           = PTR_W'(cnt);

    case (state)
      S_IDLE: begin
        if (acc) begin
          rsp_load = 1'b1;
          case (req.action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
              if (cnt == CNT_FULL) begin
                rsp_next.status = ST_FULL;
              end else begin
                ctrl.mode = (req.action == ACT_PUSH_FRONT) ? MODE_PUSHF : MODE_LOAD;
                ctrl.pos  = PTR_W'(cnt);
                cnt_next  = cnt + 1'b1;
              end
            end
            ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
              if (cnt == '0) begin
                rsp_next.status = ST_EMPTY;
              end else begin
                rd_en  = 1'b1;
                rd_idx = is_front ? '0 : IDX_W'(cnt - 1'b1);
                if (req.action == ACT_POP_FRONT) begin
                  ctrl.mode = MODE_POPF;
                  cnt_next  = cnt - 1'b1;
                end else if (req.action == ACT_POP_BACK) begin
                  cnt_next = cnt - 1'b1;
                end
              end
            end
            ACT_INSERT: begin
              if (pos_ext > cnt_ext) begin
                rsp_next.status = ST_RANGE;
              end else if (cnt == CNT_FULL) begin
                rsp_next.status = ST_FULL;
              end else begin
                ctrl.mode = MODE_INSERT;
                ctrl.pos  = PTR_W'(req.position);
                cnt_next  = cnt + 1'b1;
              end
            end
            ACT_READ_AT: begin
              if (pos_ext >= cnt_ext) begin
                rsp_next.status = ST_RANGE;
              end else begin
                rd_en  = 1'b1;
                rd_idx = IDX_W'(req.position);
              end
            end
            ACT_REVERSE: begin
              if (cnt > CNT_W'(1)) begin
                rsp_load   = 1'b0;
                state_next = S_REV;
                rev_t_next = cnt - 1'b1;
              end
            end
            ACT_SORT: begin
              if (cnt > CNT_W'(1)) begin
                rsp_load   = 1'b0;
                state_next = S_SORT;
                rnd_next   = '0;
              end
            end
            ACT_CLEAR: begin
              cnt_next = '0;
            end
            default: begin
            end
          endcase
          if (rd_en) begin
            rsp_next.value_out = 32'($signed(rd_word));
          end
        end
      end
      S_REV: begin
        ctrl.mode  = MODE_ROT;
        ctrl.pos   = PTR_W'(rev_t);
        rev_t_next = rev_t - 1'b1;
        // The step that targets slot zero would change nothing.
        if (rev_t == CNT_W'(1)) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SORT: begin
        ctrl.mode = rnd[0] ? MODE_SORT_ODD : MODE_SORT_EVEN;
        rnd_next  = rnd + 1'b1;
        if (rnd == RND_LAST) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    rsp_next.occupancy = 5'(cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rev_t <= rev_t_next;
    rnd   <= rnd_next;
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  `BDQ_ASSERT_IMP(a_full_means_full, rsp_valid && rsp.status == ST_FULL, cnt == CNT_FULL)
  `BDQ_ASSERT_IMP(a_empty_no_data, rsp_valid && rsp.status == ST_EMPTY, rsp.value_out == 32'sd0 && rsp.occupancy == 5'd0)
  `BDQ_ASSERT_IMP(a_busy_no_rsp, state != S_IDLE, !rsp_valid)
  `BDQ_ASSERT_NXT(a_sort_done_rsp, state == S_SORT && rnd == RND_LAST, rsp_valid && state == S_IDLE)

endmodule

`default_nettype wire

// ----- rtl/core/bdq_cell.sv -----
// ---------------------------------------------------------------------------
// bdq_cell
// One storage cell of the deque. It holds the word at its logical position
// and takes a new word from itself, a neighbor, cell zero or the input word.
// ---------------------------------------------------------------------------
`default_nettype none

module bdq_cell #(
  parameter int WORD_WIDTH = 32,
  parameter int INDEX      = 0
) (
  input  logic                         clk,
  input  bdq_pkg::bdq_ctrl_t           ctrl,
  input  logic signed [WORD_WIDTH-1:0] word,
  input  logic signed [WORD_WIDTH-1:0] left,
  input  logic signed [WORD_WIDTH-1:0] right,
  input  logic signed [WORD_WIDTH-1:0] first,
  output logic signed [WORD_WIDTH-1:0] value
);
  import bdq_pkg::*;

  localparam logic [PTR_W-1:0] IDX    = PTR_W'(INDEX);
  localparam logic [PTR_W-1:0] IDX_P1 = PTR_W'(INDEX + 1);

  logic signed [WORD_WIDTH-1:0] value_next;
  logic                         at_pos;
  logic                         above_pos;
  logic                         below_pos;
  logic                         phase;
  logic                         lower;
  logic                         upper;

  assign at_pos    = (ctrl.pos == IDX);
  assign above_pos = (IDX > ctrl.pos);
  assign below_pos = (IDX < ctrl.pos);
  assign phase     = (ctrl.mode == MODE_SORT_ODD);

  // In a sort round each cell but cell zero in an odd round is the lower or the upper
  // half of a pair, and only pairs that lie fully inside the stored words take part.
  assign lower = (IDX[0] == phase) && (IDX_P1 < ctrl.cnt);
  assign upper = (IDX[0] != phase) && (IDX != '0) && (IDX < ctrl.cnt);

  always_comb begin
    value_next = value;
    case (ctrl.mode)
      MODE_HOLD:   value_next = value;
      MODE_PUSHF:  value_next = left;
      MODE_LOAD: begin
        if (at_pos) value_next = word;
      end
      MODE_POPF:   value_next = right;
      MODE_INSERT: begin
        if (at_pos) value_next = word;
        else if (above_pos) value_next = left;
      end
      MODE_ROT: begin
        // Cell zero moves to the target slot; everything before it moves down.
        if (at_pos) value_next = first;
        else if (below_pos) value_next = right;
      end
      MODE_SORT_EVEN, MODE_SORT_ODD: begin
        if (lower && (right < value)) value_next = right;
        else if (upper && (left > value)) value_next = left;
      end
      default:     value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for bounded_deque_with_sort. A queue-based model of the
// deque predicts the response of every accepted item, and each response is
// compared field by field. Directed cases cover the empty, full and range
// corners; random fill-and-drain rounds and a weighted random mix follow,
// with bursty request traffic and a changing response stall pattern.
// ---------------------------------------------------------------------------

module tb;
  import bdq_pkg::*;

  localparam int DEPTH = 16;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     rsp_stall = 1'b0;
  bdq_req_t req       = '0;
  logic     req_stall;
  logic     rsp_valid;
  bdq_rsp_t rsp;

  bounded_deque_with_sort #(
    .DEPTH(DEPTH),
    .WORD_WIDTH(32)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #5 clk = ~clk;

  // Model contents in logical order, front first.
  logic signed [31:0] deque_words[$];
  bdq_rsp_t           pending_rsps[$];
  bdq_rsp_t           want_rsp;
  int                 mismatch_count = 0;

  // Sender burst shaping.
  int burst_left = 8;
  bit valid_up   = 1'b0;

  // Receiver stall pattern.
  int stall_tick = 0;
  int stall_mode = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic bdq_rsp_t deque_apply(input bdq_req_t item);
    bdq_rsp_t           r;
    int                 n;
    int                 j;
    logic signed [31:0] t;
    logic signed [31:0] tmp[$];
    r = '0;
    r.status = ST_OK;
    n = deque_words.size();
    case (item.action)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (n >= DEPTH) r.status = ST_FULL;
        else if (item.action == ACT_PUSH_FRONT) deque_words.insert(0, item.value_in);
        else deque_words.insert(n, item.value_in);
      end
      ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else if (item.action == ACT_POP_FRONT) begin
          r.value_out = deque_words[0];
          deque_words.delete(0);
        end else if (item.action == ACT_POP_BACK) begin
          r.value_out = deque_words[n-1];
          deque_words.delete(n - 1);
        end else if (item.action == ACT_PEEK_FRONT) begin
          r.value_out = deque_words[0];
        end else begin
          r.value_out = deque_words[n-1];
        end
      end
      ACT_INSERT: begin
        // The range check wins over the full check.
        if (item.position > n) r.status = ST_RANGE;
        else if (n >= DEPTH) r.status = ST_FULL;
        else deque_words.insert(item.position, item.value_in);
      end
      ACT_READ_AT: begin
        if (item.position >= n) r.status = ST_RANGE;
        else r.value_out = deque_words[item.position];
      end
      ACT_REVERSE: begin
        for (int i = 0; i < n; i++) tmp.insert(0, deque_words[i]);
        deque_words = tmp;
      end
      ACT_SORT: begin
        tmp = deque_words;
        for (int i = 1; i < n; i++) begin
          t = tmp[i];
          j = i;
          while (j > 0 && tmp[j-1] > t) begin
            tmp[j] = tmp[j-1];
            j--;
          end
          tmp[j] = t;
        end
        deque_words = tmp;
      end
      ACT_CLEAR: deque_words.delete();
      default: ;
    endcase
    r.occupancy = 5'(deque_words.size());
    return r;
  endfunction

  function automatic bdq_req_t make_item(input logic [3:0] action,
                                         input logic signed [31:0] value,
                                         input logic [4:0] position);
    bdq_req_t item;
    item.action   = action;
    item.value_in = value;
    item.position = position;
    return item;
  endfunction

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      1, 2: return $signed($urandom_range(0, 6)) - 3;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic [4:0] rand_position(input int n);
    if ($urandom_range(0, 6) == 0) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, n));
  endfunction

  // Drive one item, wait for it to be taken, then record its response.
  task automatic send_item(input bdq_req_t item);
    req_valid <= 1'b1;
    req       <= item;
    valid_up   = 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_rsps.insert(pending_rsps.size(), deque_apply(item));
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        req_valid <= 1'b0;
        valid_up   = 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // Hold off the sender until every outstanding response has drained.
  task automatic wait_for_drain();
    if (valid_up) begin
      req_valid <= 1'b0;
      valid_up   = 1'b0;
    end
    while (pending_rsps.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_corners();
    send_item(make_item(ACT_POP_FRONT, 32'sd5, 5'd0));
    send_item(make_item(ACT_POP_BACK, -32'sd5, 5'd31));
    send_item(make_item(ACT_PEEK_FRONT, 32'sd0, 5'd0));
    send_item(make_item(ACT_PEEK_BACK, 32'sd0, 5'd0));
    send_item(make_item(ACT_READ_AT, 32'sd0, 5'd0));
    send_item(make_item(ACT_INSERT, 32'sd9, 5'd1));
    send_item(make_item(ACT_REVERSE, 32'sd0, 5'd0));
    send_item(make_item(ACT_SORT, 32'sd0, 5'd0));
    send_item(make_item(4'(ACT_CLEAR + 5), 32'sh7FFF_FFFF, 5'd31));
  endtask

  task automatic test_basic_actions();
    send_item(make_item(ACT_PUSH_BACK, 32'sh7FFF_FFFF, 5'd0));
    send_item(make_item(ACT_PUSH_FRONT, 32'sh8000_0000, 5'd0));
    send_item(make_item(ACT_INSERT, 32'sd0, 5'd1));
    send_item(make_item(ACT_INSERT, -32'sd1, 5'd3));
    send_item(make_item(ACT_READ_AT, 32'sd0, 5'd3));
    send_item(make_item(ACT_READ_AT, 32'sd0, 5'd4));
    send_item(make_item(ACT_PEEK_FRONT, 32'sd0, 5'd0));
    send_item(make_item(ACT_PEEK_BACK, 32'sd0, 5'd0));
    send_item(make_item(ACT_REVERSE, 32'sd0, 5'd0));
    send_item(make_item(ACT_SORT, 32'sd0, 5'd0));
    send_item(make_item(ACT_POP_FRONT, 32'sd0, 5'd0));
    send_item(make_item(ACT_POP_BACK, 32'sd0, 5'd0));
    send_item(make_item(4'(ACT_CLEAR + 1), 32'sd0, 5'd0));
    send_item(make_item(ACT_CLEAR, 32'sd0, 5'd0));
    send_item(make_item(ACT_READ_AT, 32'sd0, 5'd0));
  endtask

  // Fill to full, hit both full paths, rework the contents, then drain.
  task automatic test_fill_and_drain(input int rounds);
    logic [3:0] act;
    for (int r = 0; r < rounds; r++) begin
      while (deque_words.size() < DEPTH) begin
        case ($urandom_range(0, 2))
          0: act = ACT_PUSH_FRONT;
          1: act = ACT_PUSH_BACK;
          default: act = ACT_INSERT;
        endcase
        send_item(make_item(act, rand_word(), 5'($urandom_range(0, deque_words.size()))));
      end
      send_item(make_item(ACT_PUSH_FRONT, rand_word(), 5'($urandom())));
      send_item(make_item(ACT_PUSH_BACK, rand_word(), 5'($urandom())));
      send_item(make_item(ACT_INSERT, rand_word(), 5'($urandom_range(0, DEPTH))));
      send_item(make_item(ACT_INSERT, rand_word(), 5'($urandom_range(DEPTH + 1, 31))));
      send_item(make_item(ACT_SORT, rand_word(), 5'($urandom())));
      send_item(make_item(ACT_READ_AT, rand_word(), 5'($urandom_range(0, DEPTH - 1))));
      send_item(make_item(ACT_REVERSE, rand_word(), 5'($urandom())));
      send_item(make_item(ACT_READ_AT, rand_word(), 5'(DEPTH)));
      while (deque_words.size() > 0) begin
        act = ($urandom_range(0, 1) != 0) ? ACT_POP_FRONT : ACT_POP_BACK;
        send_item(make_item(act, rand_word(), 5'($urandom())));
      end
      send_item(make_item(ACT_POP_BACK, rand_word(), 5'($urandom())));
    end
  endtask

  // Weighted random traffic that swings between filling and emptying.
  task automatic test_random_mix(input int count);
    bit         grow;
    int         pick;
    logic [3:0] act;
    logic [4:0] pos;
    grow = 1'b1;
    for (int k = 0; k < count; k++) begin
      if (grow && deque_words.size() == DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
      if (!grow && deque_words.size() == 0 && $urandom_range(0, 1) == 0) grow = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 30) act = grow ? (($urandom_range(0, 1) != 0) ? ACT_PUSH_FRONT : ACT_PUSH_BACK)
                                : (($urandom_range(0, 1) != 0) ? ACT_POP_FRONT : ACT_POP_BACK);
      else if (pick < 40) act = grow ? ACT_INSERT : ACT_POP_FRONT;
      else if (pick < 48) act = ($urandom_range(0, 1) != 0) ? ACT_POP_BACK : ACT_PUSH_BACK;
      else if (pick < 58) act = ($urandom_range(0, 1) != 0) ? ACT_PEEK_FRONT : ACT_PEEK_BACK;
      else if (pick < 68) act = ACT_READ_AT;
      else if (pick < 74) act = ACT_INSERT;
      else if (pick < 82) act = ACT_REVERSE;
      else if (pick < 91) act = ACT_SORT;
      else if (pick < 93) act = ACT_CLEAR;
      else if (pick < 96) act = 4'(ACT_CLEAR + $urandom_range(1, 5));
      else act = 4'($urandom_range(0, 15));
      if (act == ACT_INSERT || act == ACT_READ_AT) pos = rand_position(deque_words.size());
      else pos = 5'($urandom());
      send_item(make_item(act, rand_word(), pos));
    end
  endtask

  // Response stall pattern, in one of four modes that is picked anew at random.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 256 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      2: rsp_stall <= ($urandom_range(0, 9) < 6);
      default: rsp_stall <= ((stall_tick % 16) < 11);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsps.size() == 0) begin
        report_mismatch("response with no item outstanding, occupancy",
                        int'(rsp.occupancy), -1);
      end else begin
        want_rsp = pending_rsps[0];
        pending_rsps.delete(0);
        if (rsp.value_out !== want_rsp.value_out)
          report_mismatch("value_out", rsp.value_out, want_rsp.value_out);
        if (rsp.status !== want_rsp.status)
          report_mismatch("status", int'(rsp.status), int'(want_rsp.status));
        if (rsp.occupancy !== want_rsp.occupancy)
          report_mismatch("occupancy", int'(rsp.occupancy), int'(want_rsp.occupancy));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_corners();
    test_basic_actions();
    wait_for_drain();
    test_fill_and_drain(4);
    wait_for_drain();
    test_random_mix(330);
    wait_for_drain();
    test_random_mix(330);
    wait_for_drain();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_rsps.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
